// ===== sv/ppmp_pkg.sv =====
`timescale 1ns / 1ps
package ppmp_pkg;

  localparam int unsigned MAX_DIM = 4096;
  // A dimension above 4096 is flagged as too large (E_BIG).
  localparam int unsigned DIM_CAP = (MAX_DIM < 4096) ? MAX_DIM : 4096;
  localparam int unsigned QUEUE_DEPTH = 2;

  // Record kinds
  localparam logic [2:0] K_WIDTH  = 3'd0;
  localparam logic [2:0] K_HEIGHT = 3'd1;
  localparam logic [2:0] K_MAXVAL = 3'd2;
  localparam logic [2:0] K_SAMPLE = 3'd3;
  localparam logic [2:0] K_DONE   = 3'd4;
  localparam logic [2:0] K_ERROR  = 3'd5;

  // Error codes
  localparam logic [2:0] E_NONE   = 3'd0;
  localparam logic [2:0] E_MAGIC  = 3'd1;
  localparam logic [2:0] E_HEADER = 3'd2;
  localparam logic [2:0] E_DIMS   = 3'd3;
  localparam logic [2:0] E_MAXVAL = 3'd4;
  localparam logic [2:0] E_SHORT  = 3'd5;
  localparam logic [2:0] E_RANGE  = 3'd6;
  localparam logic [2:0] E_BIG    = 3'd7;

  // Token event from the tokenizer to the record engine
  typedef struct packed {
    logic        eos;       // end of stream
    logic        has_tok;   // a token ended with this event
    logic        magic_ok;  // token is exactly "P3"
    logic        num_ok;    // well-formed signed 32-bit decimal
    logic        negative;
    logic [31:0] magnitude;
  } tok_ev_t;

  typedef struct packed {
    logic [2:0]  kind;
    logic [12:0] value;
    logic [2:0]  code;
    logic        last;
  } rec_t;

  function automatic rec_t mk_rec(logic [2:0] kind, logic [12:0] value,
                                  logic [2:0] code, logic last);
    rec_t r;
    r.kind  = kind;
    r.value = value;
    r.code  = code;
    r.last  = last;
    return r;
  endfunction

endpackage

// ===== sv/ppmp_in_if.sv =====
`timescale 1ns / 1ps
interface ppmp_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] char_code;
  logic       end_of_stream;

  modport source (output valid, output char_code, output end_of_stream, input ready);
  modport sink   (input valid, input char_code, input end_of_stream, output ready);
endinterface

// ===== sv/ppmp_out_if.sv =====
`timescale 1ns / 1ps
interface ppmp_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  record_kind;
  logic [12:0] out_value;
  logic [2:0]  fault_code;
  logic        last_record;

  modport source (output valid, output record_kind, output out_value,
                  output fault_code, output last_record, input ready);
  modport sink   (input valid, input record_kind, input out_value,
                  input fault_code, input last_record, output ready);
endinterface

// ===== sv/ppmp_front.sv =====
`timescale 1ns / 1ps
module ppmp_front (
  input  logic               clk_i,
  input  logic               rst_ni,
  ppmp_in_if.sink            in_if,
  input  logic               full_i,
  output logic               push_o,
  output ppmp_pkg::tok_ev_t  ev_o
);
  import ppmp_pkg::*;

  logic        in_token_q, in_token_d;
  logic        in_comment_q, in_comment_d;
  logic        neg_q, neg_d;
  logic [31:0] mag_q, mag_d;
  logic        num_inv_q, num_inv_d;
  logic        digits_q, digits_d;
  logic [1:0]  len_q, len_d;
  logic        magic_inv_q, magic_inv_d;

  logic       accept;
  logic       is_space;
  logic [7:0] c;

  assign in_if.ready = !full_i;
  assign accept      = in_if.valid && in_if.ready;
  assign c           = in_if.char_code;
  assign is_space    = (c == 8'd32) || (c >= 8'd9 && c <= 8'd13);

  always_comb begin
    logic        fresh;
    logic [1:0]  pos;
    logic        neg_s, inv_s, dig_s, minv_s;
    logic [31:0] mag_s;
    logic [35:0] v;
    logic [35:0] lim;

    in_token_d   = in_token_q;
    in_comment_d = in_comment_q;
    neg_d        = neg_q;
    mag_d        = mag_q;
    num_inv_d    = num_inv_q;
    digits_d     = digits_q;
    len_d        = len_q;
    magic_inv_d  = magic_inv_q;
    push_o       = 1'b0;

    fresh  = !in_token_q;
    pos    = fresh ? 2'd0 : len_q;
    neg_s  = fresh ? 1'b0 : neg_q;
    inv_s  = fresh ? 1'b0 : num_inv_q;
    dig_s  = fresh ? 1'b0 : digits_q;
    minv_s = fresh ? 1'b0 : magic_inv_q;
    mag_s  = fresh ? 32'd0 : mag_q;
    v      = ({4'd0, mag_s} << 3) + ({4'd0, mag_s} << 1) + 36'(c - 8'd48);
    lim    = neg_s ? 36'h080000000 : 36'h07FFFFFFF;

    ev_o.eos       = in_if.end_of_stream;
    ev_o.has_tok   = in_token_q;
    ev_o.magic_ok  = !magic_inv_q && (len_q == 2'd2);
    ev_o.num_ok    = !num_inv_q && digits_q;
    ev_o.negative  = neg_q;
    ev_o.magnitude = mag_q;

    if (accept) begin
      if (in_if.end_of_stream) begin
        push_o       = 1'b1;
        in_token_d   = 1'b0;
        in_comment_d = 1'b0;
        neg_d        = 1'b0;
        mag_d        = 32'd0;
        num_inv_d    = 1'b0;
        digits_d     = 1'b0;
        len_d        = 2'd0;
        magic_inv_d  = 1'b0;
      end else if (in_comment_q) begin
        if (c == 8'd10) in_comment_d = 1'b0;
      end else if (is_space) begin
        if (in_token_q) begin
          push_o     = 1'b1;
          in_token_d = 1'b0;
        end
      end else if (fresh && c == 8'd35) begin
        in_comment_d = 1'b1;
      end else begin
        in_token_d  = 1'b1;
        len_d       = (pos == 2'd3) ? 2'd3 : pos + 2'd1;
        magic_inv_d = minv_s || !((pos == 2'd0 && c == 8'd80) ||
                                  (pos == 2'd1 && c == 8'd51));
        neg_d       = neg_s;
        mag_d       = mag_s;
        num_inv_d   = inv_s;
        digits_d    = dig_s;
        if (c >= 8'd48 && c <= 8'd57) begin
          digits_d = 1'b1;
          if (v > lim) num_inv_d = 1'b1;
          else if (!inv_s) mag_d = v[31:0];
        end else if (pos == 2'd0 && (c == 8'd45 || c == 8'd43)) begin
          neg_d = (c == 8'd45);
        end else begin
          num_inv_d = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_token_q   <= 1'b0;
      in_comment_q <= 1'b0;
      neg_q        <= 1'b0;
      mag_q        <= 32'd0;
      num_inv_q    <= 1'b0;
      digits_q     <= 1'b0;
      len_q        <= 2'd0;
      magic_inv_q  <= 1'b0;
    end else begin
      in_token_q   <= in_token_d;
      in_comment_q <= in_comment_d;
      neg_q        <= neg_d;
      mag_q        <= mag_d;
      num_inv_q    <= num_inv_d;
      digits_q     <= digits_d;
      len_q        <= len_d;
      magic_inv_q  <= magic_inv_d;
    end
  end

endmodule

// ===== sv/ppmp_fifo.sv =====
`timescale 1ns / 1ps
module ppmp_fifo (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push_i,
  input  ppmp_pkg::tok_ev_t  data_i,
  output logic               full_o,
  input  logic               pop_i,
  output ppmp_pkg::tok_ev_t  data_o,
  output logic               empty_o
);
  import ppmp_pkg::*;

  localparam int unsigned AW = $clog2(QUEUE_DEPTH);

  tok_ev_t         mem_q [QUEUE_DEPTH];
  logic [AW-1:0]   wptr_q, rptr_q;
  logic [AW:0]     cnt_q;

  assign full_o  = (cnt_q == (AW + 1)'(QUEUE_DEPTH));
  assign empty_o = (cnt_q == '0);
  assign data_o  = mem_q[rptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wptr_q] <= data_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      if (push_i) wptr_q <= (wptr_q == AW'(QUEUE_DEPTH - 1)) ? '0 : wptr_q + 1'b1;
      if (pop_i)  rptr_q <= (rptr_q == AW'(QUEUE_DEPTH - 1)) ? '0 : rptr_q + 1'b1;
      cnt_q <= cnt_q + (AW + 1)'(push_i) - (AW + 1)'(pop_i);
    end
  end

endmodule

// ===== sv/ppmp_back.sv =====
`timescale 1ns / 1ps
module ppmp_back (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               empty_i,
  input  ppmp_pkg::tok_ev_t  ev_i,
  output logic               pop_o,
  ppmp_out_if.source         out_if
);
  import ppmp_pkg::*;

  typedef enum logic [2:0] {
    PH_MAGIC, PH_WIDTH, PH_HEIGHT, PH_MAXV, PH_SAMPLES, PH_HALT
  } phase_e;

  typedef enum logic [1:0] {S_IDLE, S_DIV, S_OUT} st_e;

  st_e         st_q, st_d;
  phase_e      phase_q, phase_d;
  logic        dims_bad_q, dims_bad_d;
  logic        dims_big_q, dims_big_d;
  logic [12:0] width_q, width_d;
  logic [12:0] height_q, height_d;
  logic [7:0]  max_q, max_d;
  logic [25:0] left_q, left_d;
  rec_t        rec1_q, rec1_d;
  rec_t        rec2_q, rec2_d;
  logic        has2_q, has2_d;
  logic        eos_pend_q, eos_pend_d;
  logic [9:0]  rem_q, rem_d;
  logic [7:0]  low_q, low_d;
  logic [7:0]  quo_q, quo_d;
  logic [2:0]  cnt_q, cnt_d;

  logic [9:0]  den;
  logic [25:0] pixels3;
  logic        godiv;

  assign den     = {1'b0, max_q, 1'b0};
  assign pixels3 = 26'((width_q * height_q) * 3);

  assign out_if.valid       = (st_q == S_OUT);
  assign out_if.record_kind = rec1_q.kind;
  assign out_if.out_value   = rec1_q.value;
  assign out_if.fault_code  = rec1_q.code;
  assign out_if.last_record = rec1_q.last;

  always_comb begin
    logic        hv, ev;
    rec_t        hrec, erec;
    logic [2:0]  ecode;
    phase_e      ph;
    logic        v_le0, v_big, v_gt255, v_neg;
    logic [12:0] clamp;
    logic [16:0] num;
    logic [9:0]  sh;
    logic        qb;
    logic [7:0]  qv;
    logic [25:0] left_n;

    st_d       = st_q;
    phase_d    = phase_q;
    dims_bad_d = dims_bad_q;
    dims_big_d = dims_big_q;
    width_d    = width_q;
    height_d   = height_q;
    max_d      = max_q;
    left_d     = left_q;
    rec1_d     = rec1_q;
    rec2_d     = rec2_q;
    has2_d     = has2_q;
    eos_pend_d = eos_pend_q;
    rem_d      = rem_q;
    low_d      = low_q;
    quo_d      = quo_q;
    cnt_d      = cnt_q;
    pop_o      = 1'b0;
    godiv      = 1'b0;

    hv    = 1'b0;
    ev    = 1'b0;
    ecode = E_NONE;
    ph    = phase_q;
    hrec  = mk_rec(K_WIDTH, 13'd0, E_NONE, 1'b0);
    v_neg   = ev_i.negative && (ev_i.magnitude != 32'd0);
    v_le0   = ev_i.negative || (ev_i.magnitude == 32'd0);
    v_big   = !ev_i.negative && (ev_i.magnitude > 32'(DIM_CAP));
    v_gt255 = !ev_i.negative && (ev_i.magnitude > 32'd255);
    clamp   = ev_i.negative ? 13'd0 :
              (ev_i.magnitude > 32'd8191) ? 13'd8191 : ev_i.magnitude[12:0];
    num     = 17'(ev_i.magnitude[7:0]) * 17'd510 + 17'(max_q);
    sh      = {rem_q[8:0], low_q[7]};
    qb      = (sh >= den);
    qv      = {quo_q[6:0], qb};
    left_n  = left_q - 26'(left_q != 26'd0);

    case (st_q)
      S_IDLE: begin
        if (!empty_i) begin
          pop_o = 1'b1;
          if (phase_q != PH_HALT && (!ev_i.eos || ev_i.has_tok)) begin
            case (phase_q)
              PH_MAGIC: begin
                if (!ev_i.magic_ok) begin
                  ev = 1'b1; ecode = E_MAGIC;
                end else ph = PH_WIDTH;
              end
              PH_WIDTH, PH_HEIGHT: begin
                if (!ev_i.num_ok) begin
                  ev = 1'b1; ecode = E_HEADER;
                end else begin
                  hv   = 1'b1;
                  hrec = mk_rec((phase_q == PH_WIDTH) ? K_WIDTH : K_HEIGHT,
                                clamp, E_NONE, 1'b0);
                  if (v_le0) dims_bad_d = 1'b1;
                  if (v_big) dims_big_d = 1'b1;
                  if (phase_q == PH_WIDTH) begin
                    width_d = clamp; ph = PH_HEIGHT;
                  end else begin
                    height_d = clamp; ph = PH_MAXV;
                  end
                end
              end
              PH_MAXV: begin
                if (!ev_i.num_ok) begin
                  ev = 1'b1; ecode = E_HEADER;
                end else begin
                  hv   = 1'b1;
                  hrec = mk_rec(K_MAXVAL, clamp, E_NONE, 1'b0);
                  if (dims_bad_q) begin
                    ev = 1'b1; ecode = E_DIMS;
                  end else if (v_le0 || v_gt255) begin
                    ev = 1'b1; ecode = E_MAXVAL;
                  end else if (dims_big_q) begin
                    ev = 1'b1; ecode = E_BIG;
                  end else begin
                    max_d  = ev_i.magnitude[7:0];
                    left_d = pixels3;
                    ph     = PH_SAMPLES;
                  end
                end
              end
              PH_SAMPLES: begin
                if (!ev_i.num_ok) begin
                  ev = 1'b1; ecode = E_SHORT;
                end else if (v_neg || (!ev_i.negative &&
                             ev_i.magnitude > {24'd0, max_q}) || max_q == 8'd0) begin
                  ev = 1'b1; ecode = E_RANGE;
                end else godiv = 1'b1;
              end
              default: ;
            endcase
          end
          // unfinished image at end of stream
          if (ev_i.eos && !godiv && !ev) begin
            case (ph)
              PH_MAGIC:   begin ev = 1'b1; ecode = E_MAGIC; end
              PH_SAMPLES: begin ev = 1'b1; ecode = E_SHORT; end
              PH_HALT:    ;
              default:    begin ev = 1'b1; ecode = E_HEADER; end
            endcase
          end
          erec = mk_rec(K_ERROR, 13'd0, ecode, 1'b1);
          if (godiv) begin
            st_d       = S_DIV;
            eos_pend_d = ev_i.eos;
            rem_d      = {1'b0, num[16:8]};
            low_d      = num[7:0];
            quo_d      = 8'd0;
            cnt_d      = 3'd0;
          end else begin
            phase_d = ev ? PH_HALT : ph;
            if (hv || ev) begin
              st_d   = S_OUT;
              rec1_d = hv ? hrec : erec;
              rec2_d = erec;
              has2_d = hv && ev;
            end
            if (ev_i.eos) begin
              phase_d    = PH_MAGIC;
              dims_bad_d = 1'b0;
              dims_big_d = 1'b0;
              width_d    = 13'd0;
              height_d   = 13'd0;
              max_d      = 8'd0;
              left_d     = 26'd0;
            end
          end
        end
      end
      S_DIV: begin
        rem_d = qb ? sh - den : sh;
        low_d = {low_q[6:0], 1'b0};
        quo_d = qv;
        cnt_d = cnt_q + 3'd1;
        if (cnt_q == 3'd7) begin
          st_d   = S_OUT;
          rec1_d = mk_rec(K_SAMPLE, {5'd0, qv}, E_NONE, 1'b0);
          left_d = left_n;
          has2_d = 1'b0;
          if (left_n == 26'd0) begin
            rec2_d  = mk_rec(K_DONE, 13'd0, E_NONE, 1'b1);
            has2_d  = 1'b1;
            phase_d = PH_HALT;
          end else if (eos_pend_q) begin
            rec2_d  = mk_rec(K_ERROR, 13'd0, E_SHORT, 1'b1);
            has2_d  = 1'b1;
            phase_d = PH_HALT;
          end
          if (eos_pend_q) begin
            phase_d    = PH_MAGIC;
            dims_bad_d = 1'b0;
            dims_big_d = 1'b0;
            width_d    = 13'd0;
            height_d   = 13'd0;
            max_d      = 8'd0;
            left_d     = 26'd0;
          end
        end
      end
      S_OUT: begin
        if (out_if.ready) begin
          if (has2_q) begin
            rec1_d = rec2_q;
            has2_d = 1'b0;
          end else st_d = S_IDLE;
        end
      end
      default: st_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q       <= S_IDLE;
      phase_q    <= PH_MAGIC;
      dims_bad_q <= 1'b0;
      dims_big_q <= 1'b0;
      width_q    <= 13'd0;
      height_q   <= 13'd0;
      max_q      <= 8'd0;
      left_q     <= 26'd0;
      has2_q     <= 1'b0;
      eos_pend_q <= 1'b0;
      cnt_q      <= 3'd0;
    end else begin
      st_q       <= st_d;
      phase_q    <= phase_d;
      dims_bad_q <= dims_bad_d;
      dims_big_q <= dims_big_d;
      width_q    <= width_d;
      height_q   <= height_d;
      max_q      <= max_d;
      left_q     <= left_d;
      has2_q     <= has2_d;
      eos_pend_q <= eos_pend_d;
      cnt_q      <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rec1_q <= rec1_d;
    rec2_q <= rec2_d;
    rem_q  <= rem_d;
    low_q  <= low_d;
    quo_q  <= quo_d;
  end

`ifndef ASSERT_OFF
  a_div_rem: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (st_q == S_DIV) |-> (rem_q < den))
    else $error("divider remainder not below divisor");
  a_eos_rearm: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (st_q == S_IDLE && pop_o && ev_i.eos && !godiv) |=> (phase_q == PH_MAGIC))
    else $error("end of stream did not rearm parser");
  a_second_rec: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (st_q == S_OUT && has2_q && out_if.ready) |=> (st_q == S_OUT))
    else $error("second record dropped");
  a_left_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == PH_SAMPLES) |-> (left_q != 26'd0))
    else $error("sample phase with no samples left");
`endif

endmodule

// ===== sv/ppm_ascii_image_parser.sv =====
`timescale 1ns / 1ps
// A header record passes from the tokenizer through the token queue into the record register;
// a sample record also passes through the radix-2 scaling divider before it leaves.
// Throughput: one character per cycle while the 2-entry token queue has room; the record
// engine takes one token at a time and holds it through the divider, through a second
// record and through any output stall.
// Reset: rst_ni is asynchronous, active low, clears all control state; no clearing pass.
module ppm_ascii_image_parser (
  input  logic       clk_i,
  input  logic       rst_ni,
  ppmp_in_if.sink    in_if,
  ppmp_out_if.source out_if
);
  import ppmp_pkg::*;

  // Tokenizer -> queue -> record engine. The queue carries one entry per
  // finished token or end of stream, so the tokenizer keeps taking
  // characters while the engine divides or waits on the output, as long as the queue has room.
  logic    push, full, pop, empty;
  tok_ev_t ev_in, ev_out;

  ppmp_front u_front (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_if  (in_if),
    .full_i (full),
    .push_o (push),
    .ev_o   (ev_in)
  );

  ppmp_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  (ev_in),
    .full_o  (full),
    .pop_i   (pop),
    .data_o  (ev_out),
    .empty_o (empty)
  );

  // Header checks, sample scaling, done and error records.
  ppmp_back u_back (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .empty_i (empty),
    .ev_i    (ev_out),
    .pop_o   (pop),
    .out_if  (out_if)
  );

endmodule

// ===== sim/ppm_ascii_image_parser_tb.sv =====
`timescale 1ns / 1ps
module ppm_ascii_image_parser_tb;
  import ppmp_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 400000;

  // parser phases
  typedef enum logic [2:0] {
    PH_MAGIC, PH_WIDTH, PH_HEIGHT, PH_MAXV, PH_SAMPLES, PH_HALT
  } phase_e;

  logic clk_i;
  logic rst_ni;

  ppmp_in_if  char_ch ();
  ppmp_out_if rec_ch ();

  ppm_ascii_image_parser dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_if  (char_ch.sink),
    .out_if (rec_ch.source)
  );

  // Scoreboard: predicts the records of each accepted character and
  // compares the records that come out, oldest first.
  class ppm_scoreboard;
    phase_e      phase;
    bit          in_tok, in_cmt, neg, bad, digits, dims_bad, dims_big;
    bit [31:0]   mag;
    int unsigned tlen;
    bit [12:0]   img_w, img_h;
    bit [7:0]    max_s;
    bit [25:0]   left;
    rec_t        pending_recs[$];
    int unsigned n_chars, n_recs, n_errs;

    function new();
      rearm();
      n_chars = 0;
      n_recs  = 0;
      n_errs  = 0;
    endfunction

    function void rearm();
      phase = PH_MAGIC;
      in_tok = 0; in_cmt = 0; neg = 0; bad = 0; digits = 0;
      dims_bad = 0; dims_big = 0;
      mag = 0; tlen = 0; img_w = 0; img_h = 0; max_s = 0; left = 0;
    endfunction

    function void push(logic [2:0] kind, logic [12:0] val, logic [2:0] code, logic last);
      pending_recs.insert(pending_recs.size(), mk_rec(kind, val, code, last));
    endfunction

    function void halt_with(logic [2:0] code);
      phase = PH_HALT;
      push(K_ERROR, 13'd0, code, 1'b1);
    endfunction

    function void take_char(bit [7:0] c);
      int unsigned pos;
      longint unsigned lim, v;
      pos = tlen;
      if (tlen < 3) tlen++;
      if (phase == PH_MAGIC) begin
        if (!((pos == 0 && c == "P") || (pos == 1 && c == "3"))) bad = 1;
        return;
      end
      if (c >= "0" && c <= "9") begin
        lim = neg ? 64'd2147483648 : 64'd2147483647;
        v = longint'(mag) * 10 + (c - "0");
        digits = 1;
        if (v > lim) bad = 1;
        else if (!bad) mag = v[31:0];
      end else if (pos == 0 && (c == "-" || c == "+")) begin
        neg = (c == "-");
      end else begin
        bad = 1;
      end
    endfunction

    function void end_token();
      bit ok;
      longint signed v;
      bit [12:0] clamped;
      bit [31:0] scaled;
      ok = !bad && digits;
      v = neg ? -longint'(mag) : longint'(mag);
      clamped = (v < 0) ? 13'd0 : ((v > 8191) ? 13'd8191 : v[12:0]);
      in_tok = 0;
      case (phase)
        PH_MAGIC: begin
          if (bad || tlen != 2) halt_with(E_MAGIC);
          else phase = PH_WIDTH;
        end
        PH_WIDTH, PH_HEIGHT: begin
          if (!ok) begin
            halt_with(E_HEADER);
            return;
          end
          push(phase == PH_WIDTH ? K_WIDTH : K_HEIGHT, clamped, E_NONE, 1'b0);
          if (v <= 0) dims_bad = 1;
          if (v > longint'(DIM_CAP)) dims_big = 1;
          if (phase == PH_WIDTH) begin
            img_w = clamped;
            phase = PH_HEIGHT;
          end else begin
            img_h = clamped;
            phase = PH_MAXV;
          end
        end
        PH_MAXV: begin
          if (!ok) begin
            halt_with(E_HEADER);
            return;
          end
          push(K_MAXVAL, clamped, E_NONE, 1'b0);
          if (dims_bad) halt_with(E_DIMS);
          else if (v <= 0 || v > 255) halt_with(E_MAXVAL);
          else if (dims_big) halt_with(E_BIG);
          else begin
            max_s = v[7:0];
            left = 26'(img_w * img_h * 3);
            phase = PH_SAMPLES;
          end
        end
        PH_SAMPLES: begin
          if (!ok) halt_with(E_SHORT);
          else if (v < 0 || v > longint'(max_s) || max_s == 0) halt_with(E_RANGE);
          else begin
            scaled = (2 * mag * 255 + max_s) / (2 * max_s);
            push(K_SAMPLE, scaled[12:0], E_NONE, 1'b0);
            if (left > 0) left--;
            if (left == 0) begin
              phase = PH_HALT;
              push(K_DONE, 13'd0, E_NONE, 1'b1);
            end
          end
        end
        default: ;
      endcase
    endfunction

    // one accepted input transfer
    function void note_char(bit [7:0] c, bit eos);
      n_chars++;
      if (eos) begin
        if (in_tok && !in_cmt && phase != PH_HALT) end_token();
        if (phase == PH_MAGIC) halt_with(E_MAGIC);
        else if (phase == PH_SAMPLES) halt_with(E_SHORT);
        else if (phase != PH_HALT) halt_with(E_HEADER);
        rearm();
        return;
      end
      if (phase == PH_HALT) return;
      if (in_cmt) begin
        if (c == 8'h0a) in_cmt = 0;
        return;
      end
      if (c == 8'h20 || (c >= 8'h09 && c <= 8'h0d)) begin
        if (in_tok) end_token();
        return;
      end
      if (!in_tok) begin
        if (c == "#") begin
          in_cmt = 1;
          return;
        end
        in_tok = 1; neg = 0; bad = 0; digits = 0; mag = 0; tlen = 0;
      end
      take_char(c);
    endfunction

    // one accepted output transfer
    function void check_rec(rec_t got);
      rec_t want;
      n_recs++;
      if (pending_recs.size() == 0) begin
        $error("unexpected record kind=%0d value=%0d code=%0d", got.kind, got.value,
               got.code);
        n_errs++;
        return;
      end
      want = pending_recs.pop_front();
      if (got.kind !== want.kind) begin
        $error("record_kind: expected %0d, got %0d", want.kind, got.kind);
        n_errs++;
      end
      if (got.value !== want.value) begin
        $error("out_value: expected %0d, got %0d", want.value, got.value);
        n_errs++;
      end
      if (got.code !== want.code) begin
        $error("fault_code: expected %0d, got %0d", want.code, got.code);
        n_errs++;
      end
      if (got.last !== want.last) begin
        $error("last_record: expected %0d, got %0d", want.last, got.last);
        n_errs++;
      end
    endfunction
  endclass

  ppm_scoreboard sb;
  bit [8:0] char_stream[$];    // {eos, char}
  int unsigned n_rand_files;
  int unsigned cycles;

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  // ---- stimulus builders ----
  task automatic put_str(string s);
    for (int i = 0; i < s.len(); i++) char_stream.insert(char_stream.size(), {1'b0, s[i]});
  endtask

  task automatic put_eos();
    char_stream.insert(char_stream.size(), {1'b1, 8'($urandom)});
  endtask

  // random whitespace separator, sometimes with a comment
  task automatic put_gap();
    int unsigned k;
    k = $urandom_range(0, 9);
    if (k == 0) put_str(" #c\n");
    else if (k < 3) put_str("\n");
    else if (k == 3) put_str("\t ");
    else put_str(" ");
  endtask

  // well-formed image with random content and a few rare faults
  task automatic put_image();
    int unsigned w, h, m, n, flt;
    w = $urandom_range(1, 3);
    h = $urandom_range(1, 2);
    m = ($urandom_range(0, 3) == 0) ? 255 : $urandom_range(1, 255);
    flt = $urandom_range(0, 15);
    put_str("P3"); put_gap();
    put_str($sformatf("%0d", w)); put_gap();
    put_str($sformatf("%0d", h)); put_gap();
    put_str($sformatf("%0d", m)); put_gap();
    n = w * h * 3;
    for (int i = 0; i < n; i++) begin
      if (flt == 1 && i == n - 1) put_str($sformatf("%0d", m + 1));
      else if (flt == 2 && i == n / 2) put_str("1x");
      else if (flt == 3 && i == n - 1) break;
      else if ($urandom_range(0, 4) == 0) put_str($sformatf("+%0d", $urandom_range(0, m)));
      else put_str($sformatf("%0d", $urandom_range(0, m)));
      put_gap();
    end
    if ($urandom_range(0, 3) == 0) put_str("junk 12 ");
    put_eos();
  endtask

  // random bytes, sometimes after a P3 magic, then end of stream
  task automatic put_noise();
    int unsigned n;
    n = $urandom_range(1, 12);
    if ($urandom_range(0, 1)) put_str("P3 ");
    for (int i = 0; i < n; i++) char_stream.insert(char_stream.size(), {1'b0, 8'($urandom)});
    put_eos();
  endtask

  task automatic build_stream();
    n_rand_files = 0;
    // directed: header extremes, each error code, comments, lone sign
    put_str("P3 1 1 255 0 128 255"); put_eos();                  // done via eos edge
    put_str("P3 1 1 1 0 1 1 "); put_eos();
    put_str("#x\nP3 2 1 7 # note 9\n 7 0 3 4 5 6 "); put_eos();
    put_str("P4 "); put_eos();                                   // bad magic
    put_str("P33 "); put_eos();
    put_eos();                                                   // empty file
    put_str("P3 - "); put_eos();                                 // lone sign
    put_str("P3 2147483648 "); put_eos();                        // overflow
    put_str("P3 -2147483648 1 9 "); put_eos();                   // dims
    put_str("P3 0 1 9 "); put_eos();
    put_str("P3 2 2 0 "); put_eos();                             // maxval
    put_str("P3 1 1 256 "); put_eos();
    put_str("P3 4097 1 255 "); put_eos();                        // too large
    put_str("P3 9000 1 255 "); put_eos();                        // clamp 8191
    put_str("P3 4096 4096 255 1 "); put_eos();                   // short at eos
    put_str("P3 1 1 5 6 "); put_eos();                           // range
    put_str("P3 1 1 5 -1 "); put_eos();
    put_str("P3 1 1 5 + "); put_eos();
    put_str("P3 1 1\x0b9\x0c\r0 0 0\x0a"); put_eos();
    char_stream.insert(char_stream.size(), {1'b0, 8'hff});
    char_stream.insert(char_stream.size(), {1'b0, 8'h80});
    put_eos();
    while (char_stream.size() < 500) begin
      n_rand_files++;
      if ($urandom_range(0, 4) == 0) put_noise();
      else put_image();
    end
  endtask

  // ---- sender ----
  task automatic send_all();
    bit [8:0] it;
    int unsigned gap;
    while (char_stream.size() != 0) begin
      it = char_stream.pop_front();
      gap = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 6) : 0;
      if (gap != 0) begin
        char_ch.valid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      char_ch.valid         <= 1'b1;
      char_ch.char_code     <= it[7:0];
      char_ch.end_of_stream <= it[8];
      do @(posedge clk_i); while (!char_ch.ready);
      sb.note_char(it[7:0], it[8]);
    end
    char_ch.valid <= 1'b0;
  endtask

  // ---- receiver: random ready, one long hold-off early on ----
  initial begin
    int unsigned wait_n;
    rec_ch.ready <= 1'b0;
    @(posedge rst_ni);
    repeat (40) @(posedge clk_i);
    // ready stays low here while the sender keeps offering characters
    repeat (300) @(posedge clk_i);
    forever begin
      wait_n = ($urandom_range(0, 2) == 0) ? $urandom_range(0, 6) : 0;
      if (wait_n != 0) begin
        rec_ch.ready <= 1'b0;
        repeat (wait_n) @(posedge clk_i);
      end
      rec_ch.ready <= 1'b1;
      do @(posedge clk_i); while (!rec_ch.valid);
    end
  end

  // record monitor, sampled at the edge
  always @(posedge clk_i) begin
    if (rst_ni && rec_ch.valid && rec_ch.ready)
      sb.check_rec(mk_rec(rec_ch.record_kind, rec_ch.out_value, rec_ch.fault_code,
                          rec_ch.last_record));
  end

  // watchdog
  initial begin
    cycles = 0;
    forever begin
      @(posedge clk_i);
      cycles++;
      if (cycles == CYCLE_LIMIT) begin
        $display("Mismatches found");
        $finish;
      end
    end
  end

  initial begin
    sb = new();
    rst_ni = 1'b0;
    char_ch.valid         <= 1'b0;
    char_ch.char_code     <= 8'd0;
    char_ch.end_of_stream <= 1'b0;
    build_stream();
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    send_all();
    while (sb.pending_recs.size() != 0) @(posedge clk_i);
    repeat (40) @(posedge clk_i);
    $display("Sent %0d characters (directed header and error cases, %0d random files)",
             sb.n_chars, n_rand_files);
    $display("Checked %0d records, with random gaps and a long output stall", sb.n_recs);
    if (sb.n_errs == 0) $display("No mismatches found");
    else $display("Mismatches found");
    $finish;
  end

endmodule
